[sv/b64d_pkg.sv]
// shared types, status codes and alphabet map of the base64url decoder
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned SEXT_W  = 6;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned RCNT_W  = 3;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 3;

    localparam logic [COUNT_W-1:0] CAP_RESET = 13'd4096;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1fff;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_NO_SPACE  = 2'd2
    } t_status;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              last_char;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               byte_valid;
        logic               done_res;
        logic [1:0]         status;
        logic [COUNT_W-1:0] byte_count;
    } t_out_beat;

    typedef struct packed {
        logic              ok;
        logic [SEXT_W-1:0] value;
    } t_sextet;

    // url-safe alphabet: A-Z, a-z, 0-9, '-', '_'
    function automatic t_sextet sextet_of(input logic [CHAR_W-1:0] c);
        t_sextet s;
        s.ok    = 1'b1;
        s.value = '0;
        if (c >= 8'h41 && c <= 8'h5a) begin
            s.value = SEXT_W'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            s.value = SEXT_W'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.value = SEXT_W'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2d) begin
            s.value = 6'd62;
        end else if (c == 8'h5f) begin
            s.value = 6'd63;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

[sv/base64url_strict_decoder.sv]
// top level of the strict unpadded base64url decoder
`timescale 1ns / 1ps

// Strict base64url decoder, one character per input beat with a last flag.
// A beat is registered at the input, decoded combinationally against the
// message state, and any result is registered at the output, so each
// character passes the input and output registers; the block sustains one
// character per clock while the output does not stall; the state update
// (residual bits, byte count, discard flag) sets that rate. Output stall
// is passed back to the input in the same cycle, so the input register
// keeps moving as long as the output register is empty or being drained.
// A result beat carries a decoded byte, or the final beat of the message
// with status ok, malformed (bad character, lone 6-bit group or nonzero
// leftover bits) or no space (more bytes than min(capacity, MAX_BYTES)).
// After an error the rest of the message up to its last character is
// swallowed without results. The capacity register sits at address 0 of
// the apb port and resets to 4096; write it only while the block is idle.
module base64url_strict_decoder #(
    parameter int unsigned MAX_BYTES = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  b64d_pkg::t_in_beat                i_in_beat,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output b64d_pkg::t_out_beat               o_out_beat,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [b64d_pkg::ADDR_W-1:0]       paddr,
    input  logic [b64d_pkg::DATA_W-1:0]       pwdata,
    output logic [b64d_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    // the byte count field caps any useful limit
    localparam logic [b64d_pkg::COUNT_W-1:0] LIMIT_MAX =
        (MAX_BYTES > 8191) ? b64d_pkg::COUNT_MAX : b64d_pkg::COUNT_W'(MAX_BYTES);

    logic [b64d_pkg::COUNT_W-1:0] capacity;
    logic [b64d_pkg::COUNT_W-1:0] limit;

    // input register
    logic                 r_in_valid;
    b64d_pkg::t_in_beat   r_in_beat;
    // output register
    logic                 r_out_valid, n_out_valid;
    b64d_pkg::t_out_beat  r_out_beat;

    logic                 out_load;
    logic                 step_fire;
    logic                 has_result;
    b64d_pkg::t_out_beat  result;

    b64d_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    assign limit = (capacity > LIMIT_MAX) ? LIMIT_MAX : capacity;

    // output register frees up when empty or when its beat leaves
    assign out_load  = !r_out_valid || !i_out_stall;
    // the staged character is decoded when the output side can take it
    assign step_fire = r_in_valid && out_load;
    // input register may refill when empty or when it drains this cycle
    assign o_in_stall = r_in_valid && !out_load;

    b64d_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (step_fire),
        .i_beat       (r_in_beat),
        .i_limit      (limit),
        .o_has_result (has_result),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_beat <= i_in_beat;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = step_fire && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire && has_result) begin
            r_out_beat <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

[sv/b64d_cfg.sv]
// apb-style register file holding the output capacity
`timescale 1ns / 1ps

module b64d_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [b64d_pkg::ADDR_W-1:0]         paddr,
    input  logic [b64d_pkg::DATA_W-1:0]         pwdata,
    output logic [b64d_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    output logic [b64d_pkg::COUNT_W-1:0]        o_capacity
);

    logic [b64d_pkg::COUNT_W-1:0] r_capacity;
    logic                         wr_en;

    // only register zero exists, decoded on the word address bit
    assign wr_en = psel && penable && pwrite && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= b64d_pkg::CAP_RESET;
        end else if (wr_en) begin
            r_capacity <= pwdata[b64d_pkg::COUNT_W-1:0];
        end
    end

    assign pready     = 1'b1;
    assign prdata     = paddr[2] ? '0
                      : {{(b64d_pkg::DATA_W-b64d_pkg::COUNT_W){1'b0}}, r_capacity};
    assign o_capacity = r_capacity;

endmodule

[sv/b64d_step.sv]
// per-character decode step with the message state registers
`timescale 1ns / 1ps

module b64d_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  b64d_pkg::t_in_beat            i_beat,
    input  logic [b64d_pkg::COUNT_W-1:0]  i_limit,
    output logic                          o_has_result,
    output b64d_pkg::t_out_beat           o_result
);

    logic [b64d_pkg::SEXT_W-1:0]  r_res_bits, n_res_bits;
    logic [b64d_pkg::RCNT_W-1:0]  r_res_cnt,  n_res_cnt;
    logic [b64d_pkg::COUNT_W-1:0] r_bytes_out, n_bytes_out;
    logic                         r_discard,  n_discard;

    b64d_pkg::t_sextet            sx;
    logic [b64d_pkg::RCNT_W-1:0]  nbits;
    logic [3:0]                   nsum;
    logic [2:0]                   nb;
    logic [11:0]                  acc;
    logic [11:0]                  shifted;
    logic [6:0]                   mask;
    logic                         byte_ready;
    logic [b64d_pkg::SEXT_W-1:0]  keep_bits;

    assign sx    = b64d_pkg::sextet_of(i_beat.char_in);
    assign nbits = (r_res_cnt > 3'd6) ? 3'd6 : r_res_cnt;
    assign nsum  = {1'b0, nbits} + 4'd6;
    assign byte_ready = nsum >= 4'd8;
    assign nb    = byte_ready ? 3'(nsum - 4'd8) : nsum[2:0];
    assign acc   = {r_res_bits, sx.value};
    assign shifted   = acc >> nb;
    assign mask      = (7'd1 << nb) - 7'd1;
    assign keep_bits = acc[5:0] & mask[5:0];

    always_comb begin
        n_res_bits   = r_res_bits;
        n_res_cnt    = r_res_cnt;
        n_bytes_out  = r_bytes_out;
        n_discard    = r_discard;
        o_has_result = 1'b0;
        o_result     = '0;
        if (i_fire) begin
            if (r_discard) begin
                if (i_beat.last_char) begin
                    n_discard = 1'b0;
                end
            end else if (!sx.ok || (byte_ready && r_bytes_out >= i_limit)) begin
                o_has_result        = 1'b1;
                o_result.done_res   = 1'b1;
                o_result.status     = sx.ok ? b64d_pkg::ST_NO_SPACE
                                            : b64d_pkg::ST_MALFORMED;
                o_result.byte_count = r_bytes_out;
                n_res_bits  = '0;
                n_res_cnt   = '0;
                n_bytes_out = '0;
                n_discard   = !i_beat.last_char;
            end else begin
                if (byte_ready) begin
                    o_result.out_byte   = shifted[7:0];
                    o_result.byte_valid = 1'b1;
                    n_bytes_out = r_bytes_out + 1'b1;
                end
                n_res_cnt  = nb;
                n_res_bits = keep_bits;
                if (i_beat.last_char) begin
                    o_has_result        = 1'b1;
                    o_result.done_res   = 1'b1;
                    o_result.status     = (nb >= 3'd6 || keep_bits != '0)
                                        ? b64d_pkg::ST_MALFORMED : b64d_pkg::ST_OK;
                    o_result.byte_count = n_bytes_out;
                    n_res_bits  = '0;
                    n_res_cnt   = '0;
                    n_bytes_out = '0;
                end else begin
                    o_has_result = byte_ready;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_bits  <= '0;
            r_res_cnt   <= '0;
            r_bytes_out <= '0;
            r_discard   <= 1'b0;
        end else begin
            r_res_bits  <= n_res_bits;
            r_res_cnt   <= n_res_cnt;
            r_bytes_out <= n_bytes_out;
            r_discard   <= n_discard;
        end
    end

endmodule

[sv/b64d_checker.sv]
// port-level checker for the base64url decoder, bound to the top level
`timescale 1ns / 1ps

module b64d_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_in_stall,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  b64d_pkg::t_out_beat         o_out_beat
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat changed while stalled");

    // the input side only stalls behind a stalled result beat
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result beat");

    // a beat that does not end the message always carries a byte and no status
    a_mid_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.done_res |->
            o_out_beat.byte_valid && o_out_beat.status == b64d_pkg::ST_OK
            && o_out_beat.byte_count == '0)
        else $error("mid-message beat without byte or with status");

    // a no-space result never delivers a byte
    a_nospace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.status == b64d_pkg::ST_NO_SPACE |->
            !o_out_beat.byte_valid && o_out_beat.out_byte == '0)
        else $error("no-space result carries a byte");

    // a done beat with a byte has counted it
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.done_res && o_out_beat.byte_valid |->
            o_out_beat.byte_count != '0)
        else $error("byte delivered on done beat but count is zero");

endmodule

bind base64url_strict_decoder b64d_checker u_b64d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

[dv/tb_top.sv]
// self-checking testbench of the strict base64url decoder: directed table, then random messages
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned MAX_BYTES   = 4096;
    localparam int unsigned COUNT_W     = b64d_pkg::COUNT_W;
    localparam int unsigned ADDR_W      = b64d_pkg::ADDR_W;
    localparam int unsigned DATA_W      = b64d_pkg::DATA_W;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_CHARS = 100;
    // pipeline is two registers deep, so a few extra cycles cover any work in flight
    localparam int unsigned SETTLE      = 8;

    // capacity register, index 0, byte address 0
    localparam logic [ADDR_W-1:0] REG_CAPACITY = ADDR_W'(0);

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    b64d_pkg::t_in_beat   i_in_beat   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    b64d_pkg::t_out_beat  o_out_beat;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_W-1:0]    paddr       = '0;
    logic [DATA_W-1:0]    pwdata      = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    base64url_strict_decoder #(
        .MAX_BYTES(MAX_BYTES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat (o_out_beat),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // decoder model state, mirrors the block after reset
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] cap_reg   = 13'd4096;
    logic [5:0]         res_bits  = '0;
    int unsigned        res_cnt   = 0;
    logic [COUNT_W-1:0] msg_bytes = '0;
    bit                 dropping  = 1'b0;

    b64d_pkg::t_out_beat pending_results[$];
    logic [7:0]  msg_chars[$];
    int unsigned errors     = 0;
    int unsigned cycles     = 0;
    int unsigned calm_in    = 0;
    int unsigned calm_out   = 0;
    int unsigned stall_left = 0;

    // url-safe alphabet lookup; returns 0 for characters outside it
    function automatic bit char_value(input logic [7:0] c, output logic [5:0] v);
        v = '0;
        if (c >= "A" && c <= "Z") v = 6'(c - "A");
        else if (c >= "a" && c <= "z") v = 6'(c - "a" + 26);
        else if (c >= "0" && c <= "9") v = 6'(c - "0" + 52);
        else if (c == "-") v = 6'd62;
        else if (c == "_") v = 6'd63;
        else return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] value_char(input logic [5:0] v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 6'd62) ? 8'("-") : 8'("_");
    endfunction

    function automatic void end_message();
        res_bits  = '0;
        res_cnt   = 0;
        msg_bytes = '0;
    endfunction

    // advances the model by one accepted character; returns 1 when a result beat is due
    function automatic bit decode_char(input b64d_pkg::t_in_beat b,
                                       output b64d_pkg::t_out_beat r);
        logic [5:0]         sx;
        logic [11:0]        acc;
        logic [COUNT_W-1:0] lim;
        int unsigned        nb;
        r   = '0;
        lim = (cap_reg > COUNT_W'(MAX_BYTES)) ? COUNT_W'(MAX_BYTES) : cap_reg;

        // rest of a failed message is swallowed up to its last character
        if (dropping) begin
            if (b.last_char) dropping = 1'b0;
            return 1'b0;
        end

        if (!char_value(b.char_in, sx)) begin
            r.done_res   = 1'b1;
            r.status     = b64d_pkg::ST_MALFORMED;
            r.byte_count = msg_bytes;
            end_message();
            dropping = !b.last_char;
            return 1'b1;
        end

        acc = {res_bits, sx};
        nb  = res_cnt + 6;
        if (nb >= 8) begin
            nb = nb - 8;
            // a byte is ready but the message is already at its limit
            if (msg_bytes >= lim) begin
                r.done_res   = 1'b1;
                r.status     = b64d_pkg::ST_NO_SPACE;
                r.byte_count = msg_bytes;
                end_message();
                dropping = !b.last_char;
                return 1'b1;
            end
            r.out_byte   = 8'(acc >> nb);
            r.byte_valid = 1'b1;
            msg_bytes    = msg_bytes + 1'b1;
        end
        res_cnt  = nb;
        res_bits = 6'(acc & ((12'd1 << nb) - 12'd1));

        if (b.last_char) begin
            // canonical end: no lone group, padding bits all zero
            r.done_res   = 1'b1;
            r.status     = (nb >= 6 || res_bits != 0) ? b64d_pkg::ST_MALFORMED
                                                      : b64d_pkg::ST_OK;
            r.byte_count = msg_bytes;
            end_message();
            return 1'b1;
        end
        return r.byte_valid;
    endfunction

    // ------------------------------------------------------------------
    // directed table; rows with fixed set carry a result read off by hand
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0]         ch;
        logic               last;
        logic               fixed;
        logic [7:0]         xbyte;
        logic               xvalid;
        logic               xdone;
        b64d_pkg::t_status  xstat;
        logic [COUNT_W-1:0] xcount;
    } t_dir_row;

    t_dir_row dir_rows [25] = '{
        // lone 6-bit group right after reset
        '{"A", 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, b64d_pkg::ST_MALFORMED, 13'd0},
        // "QQ" decodes to 0x41 with zero padding
        '{"Q", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        '{"Q", 1'b1, 1'b1, 8'h41, 1'b1, 1'b1, b64d_pkg::ST_OK,        13'd1},
        // padding character is outside the alphabet
        '{"=", 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, b64d_pkg::ST_MALFORMED, 13'd0},
        // nonzero leftover bits, byte still delivered with the done beat
        '{"A", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        '{"B", 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, b64d_pkg::ST_MALFORMED, 13'd1},
        // bad character mid-message, then the tail is swallowed
        '{"Q", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        '{"*", 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, b64d_pkg::ST_MALFORMED, 13'd0},
        '{"Q", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        '{"Q", 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        // decoding resumes cleanly on the next message
        '{"Q", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        '{"Q", 1'b1, 1'b1, 8'h41, 1'b1, 1'b1, b64d_pkg::ST_OK,        13'd1},
        // character code extremes
        '{8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, b64d_pkg::ST_MALFORMED, 13'd0},
        '{8'hff, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, b64d_pkg::ST_MALFORMED, 13'd0},
        // every alphabet range edge in one canonical 6-byte message
        '{"Z", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        '{"0", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        '{"a", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        '{"9", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        '{"-", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        '{"_", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        '{"z", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        '{"A", 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        // bad last character after a byte went out: count keeps that byte
        '{"Q", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        '{"Q", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK,        13'd0},
        '{"=", 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, b64d_pkg::ST_MALFORMED, 13'd1}
    };

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // idle cycles before a beat: mostly none, some short, a few long, with calm stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_in > 0) begin
            calm_in--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) calm_in = $urandom_range(20, 100);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // drives one character and waits for its handshake; valid stays high afterwards
    task automatic send_char(input logic [7:0] c, input logic last, input bit fixed,
                             input b64d_pkg::t_out_beat fixed_res);
        int unsigned         gap;
        b64d_pkg::t_in_beat  b;
        b64d_pkg::t_out_beat r;
        bit                  due;
        gap = pick_gap();
        @(negedge i_clk);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        b.char_in   = c;
        b.last_char = last;
        i_in_beat  <= b;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        due = decode_char(b, r);
        if (fixed) pending_results.push_back(fixed_res);
        else if (due) pending_results.push_back(r);
    endtask

    // stop sending and wait until every predicted result has been drained
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // apb write of the capacity register, then read back
    task automatic write_capacity(input logic [COUNT_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CAPACITY;
        pwdata  <= DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cap_reg = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[COUNT_W-1:0] !== value) begin
            $display("%0t capacity readback: expected %0d got %0d",
                     $time, value, prdata[COUNT_W-1:0]);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // fills msg_chars with one message: mostly canonical encodings of random bytes,
    // some with a corrupted character or padding, some plain noise
    task automatic make_message();
        int unsigned kind, r, n, nbits, pos;
        logic [15:0] acc;
        logic [5:0]  tail_sx;
        msg_chars.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 88) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                if ($urandom_range(0, 1) == 0) msg_chars.push_back(8'($urandom_range(0, 255)));
                else msg_chars.push_back(value_char(6'($urandom_range(0, 63))));
            end
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 80) n = $urandom_range(1, 12);
        else if (r < 95) n = $urandom_range(13, 40);
        else n = $urandom_range(41, 60);
        acc     = '0;
        nbits   = 0;
        tail_sx = '0;
        repeat (n) begin
            acc   = (acc << 8) | 16'($urandom_range(0, 255));
            nbits = nbits + 8;
            while (nbits >= 6) begin
                nbits = nbits - 6;
                msg_chars.push_back(value_char(6'(acc >> nbits)));
            end
        end
        if (nbits > 0) begin
            tail_sx = 6'(acc << (6 - nbits));
            msg_chars.push_back(value_char(tail_sx));
        end
        if (kind >= 80) begin
            // non-canonical: set padding bits, or leave a lone group
            if (nbits > 0)
                msg_chars[msg_chars.size()-1] =
                    value_char(tail_sx | 6'($urandom_range(1, (1 << (6 - nbits)) - 1)));
            else
                msg_chars.push_back(value_char(6'($urandom_range(0, 63))));
        end else if (kind >= 70) begin
            pos = $urandom_range(0, msg_chars.size() - 1);
            msg_chars[pos] = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] cap_value);
        int unsigned sent;
        drain();
        write_capacity(cap_value);
        sent = 0;
        while (sent < PHASE_CHARS) begin
            make_message();
            // now and then hold off until the decoder has fully caught up
            if ($urandom_range(0, 99) < 3) drain();
            foreach (msg_chars[k])
                send_char(msg_chars[k], k == msg_chars.size() - 1, 1'b0, '0);
            sent = sent + msg_chars.size();
        end
    endtask

    initial begin
        b64d_pkg::t_out_beat fixed_res;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            fixed_res.out_byte   = dir_rows[k].xbyte;
            fixed_res.byte_valid = dir_rows[k].xvalid;
            fixed_res.done_res   = dir_rows[k].xdone;
            fixed_res.status     = dir_rows[k].xstat;
            fixed_res.byte_count = dir_rows[k].xcount;
            send_char(dir_rows[k].ch, dir_rows[k].last, dir_rows[k].fixed, fixed_res);
        end

        // zero and one force early no-space, 4096 is the full limit
        run_phase(13'd0);
        run_phase(13'd1);
        run_phase(COUNT_W'($urandom_range(2, 30)));
        run_phase(13'd4096);
        run_phase(COUNT_W'($urandom_range(2, 30)));
        drain();

        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stall bursts, with quiet stretches
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : stall_gen
        int unsigned r;
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (calm_out > 0) begin
                calm_out = calm_out - 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) stall_left = $urandom_range(10, 40);
                else if (r < 35) stall_left = $urandom_range(1, 3);
                else if (r < 40) calm_out = $urandom_range(20, 80);
            end
        end
    end

    function automatic void check_field(input string what, input logic [COUNT_W-1:0] want,
                                        input logic [COUNT_W-1:0] got);
        if (got !== want) begin
            $display("%0t %s: expected %0d got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    // compare every taken result beat with the oldest prediction
    always @(posedge i_clk) begin : result_check
        b64d_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result beat: expected none got %h", $time, o_out_beat);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_byte",   COUNT_W'(want.out_byte),   COUNT_W'(o_out_beat.out_byte));
                check_field("byte_valid", COUNT_W'(want.byte_valid), COUNT_W'(o_out_beat.byte_valid));
                check_field("done_res",   COUNT_W'(want.done_res),   COUNT_W'(o_out_beat.done_res));
                check_field("status",     COUNT_W'(want.status),     COUNT_W'(o_out_beat.status));
                check_field("byte_count", want.byte_count,           o_out_beat.byte_count);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
